>>> rtl/core/pec_pkg.sv
// ----------------------------------------------------------------------------
// pec_pkg: shared definitions for the path edge overlap check
// Sizes, command and work codes, and the structs passed between the parts.
// ----------------------------------------------------------------------------
package pec_pkg;

   localparam int EDGE_ID_BITS    = 16;
   localparam int MAX_PATH_EDGES  = 1024;   // power of two
   localparam int ID_SPACE        = 1 << EDGE_ID_BITS;
   localparam int COUNT_BITS      = $clog2(MAX_PATH_EDGES + 1);
   localparam int LIST_ADDR_BITS  = $clog2(MAX_PATH_EDGES);
   localparam int PATH_BITS       = 16;
   localparam logic [PATH_BITS-1:0] PATH_MAX = {PATH_BITS{1'b1}};

   // command codes on the input channel
   localparam logic [2:0] CMD_LOAD_MAP = 3'd0;
   localparam logic [2:0] CMD_FIRST    = 3'd1;
   localparam logic [2:0] CMD_SECOND   = 3'd2;
   localparam logic [2:0] CMD_END_PATH = 3'd3;
   localparam logic [2:0] CMD_RESTART  = 3'd4;

   // work codes held in the command queue
   localparam logic [2:0] KIND_LOAD    = 3'd0;
   localparam logic [2:0] KIND_MARK    = 3'd1;
   localparam logic [2:0] KIND_CHECK   = 3'd2;
   localparam logic [2:0] KIND_END     = 3'd3;
   localparam logic [2:0] KIND_RESTART = 3'd4;

   localparam int CMDQ_DEPTH      = 4;      // power of two
   localparam int CMDQ_PTR_BITS   = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_COUNT_BITS = $clog2(CMDQ_DEPTH + 1);

   localparam int RSPQ_DEPTH      = 2;      // power of two
   localparam int RSPQ_PTR_BITS   = $clog2(RSPQ_DEPTH);
   localparam int RSPQ_COUNT_BITS = $clog2(RSPQ_DEPTH + 1);

   typedef struct packed {
      logic [2:0]              kind;
      logic [EDGE_ID_BITS-1:0] id;
      logic [EDGE_ID_BITS-1:0] value;
   } cmd_entry_type;

   typedef struct packed {
      logic          valid;
      cmd_entry_type entry;
   } cmd_head_type;

   typedef struct packed {
      logic pop;
      logic init_busy;
   } back_ctrl_type;

   typedef struct packed {
      logic [PATH_BITS-1:0] path_number;
      logic                 no_overlap;
      logic                 list_overflow;
   } rsp_item_type;

endpackage

>>> rtl/core/path_edge_overlap_check.sv
// ----------------------------------------------------------------------------
// path_edge_overlap_check: top level
// Tests whether the edge lists of the two parts of a path share an edge.
// ----------------------------------------------------------------------------
// Items go in through a queue-style port (req_push/req_full) and results come
// out through another (rsp_empty/rsp_pop). Commands: load map entry, first-part
// edge, second-part edge, end of path, restart batch; other codes are accepted
// and dropped. Only end of path yields a result: the saturating 1-based path
// number, a no-overlap flag and a list-overflow flag. After reset req_full
// stays high while the seen bitmap is cleared one entry per cycle; csr writes
// are taken throughout. In the back end a map load is written from the idle
// state; an edge goes through the registered reads of the edge map RAM (only
// with use_map set) and then the seen bitmap RAM; end of path and restart
// walk the mark list RAM read port to clear the bitmap entry of each marked
// edge. A four-entry command queue in front and a two-entry result queue
// behind let the input side and the result side stall on their own.
// ----------------------------------------------------------------------------
module path_edge_overlap_check (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_push,
   input  logic [2:0]  req_command,
   input  logic [15:0] req_edge_id,
   input  logic [15:0] req_map_value,
   output logic        req_full,
   // result channel
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [15:0] rsp_path_number,
   output logic        rsp_no_overlap,
   output logic        rsp_list_overflow,
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import pec_pkg::*;

   // use_map register: translate edge ids through the loaded map
   logic use_map_ff, use_map_in;

   cmd_head_type  cmd_head;
   back_ctrl_type back_ctrl;
   logic          rsp_full;
   logic          rsp_push;
   rsp_item_type  rsp_item;
   rsp_item_type  head_item;

   assign use_map_in = csr_wr_en ? csr_wr_data : use_map_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_map_ff <= 1'b0;
      end else begin
         use_map_ff <= use_map_in;
      end
   end

   // front: decode and buffer commands
   pec_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_command   (req_command),
      .req_edge_id   (req_edge_id),
      .req_map_value (req_map_value),
      .req_full      (req_full),
      .back_ctrl     (back_ctrl),
      .cmd_head      (cmd_head)
   );

   // back: bitmap marking, checking and the clearing walk
   pec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .use_map   (use_map_ff),
      .cmd_head  (cmd_head),
      .back_ctrl (back_ctrl),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item)
   );

   // results wait here until popped
   pec_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_item (rsp_item),
      .full      (rsp_full),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .head_item (head_item)
   );

   assign rsp_path_number   = head_item.path_number;
   assign rsp_no_overlap    = head_item.no_overlap;
   assign rsp_list_overflow = head_item.list_overflow;

endmodule

>>> rtl/core/pec_ram.sv
// ----------------------------------------------------------------------------
// pec_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pec_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/pec_front.sv
// ----------------------------------------------------------------------------
// pec_front: input side of the overlap check
// Decodes commands into work codes and buffers them in a short queue.
// ----------------------------------------------------------------------------
module pec_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic [2:0]             req_command,
   input  logic [15:0]            req_edge_id,
   input  logic [15:0]            req_map_value,
   output logic                   req_full,
   input  pec_pkg::back_ctrl_type back_ctrl,
   output pec_pkg::cmd_head_type  cmd_head
);
   import pec_pkg::*;

   cmd_entry_type              entries_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_COUNT_BITS-1:0] count_ff, count_in;

   logic [2:0]    kind;
   logic          keep;
   logic          accept;
   logic          wr;
   logic          rd;
   cmd_entry_type new_entry;

   // unused commands are taken and dropped here
   always_comb begin
      kind = KIND_LOAD;
      keep = 1'b1;
      case (req_command)
         CMD_LOAD_MAP: kind = KIND_LOAD;
         CMD_FIRST:    kind = KIND_MARK;
         CMD_SECOND:   kind = KIND_CHECK;
         CMD_END_PATH: kind = KIND_END;
         CMD_RESTART:  kind = KIND_RESTART;
         default:      keep = 1'b0;
      endcase
   end

   assign new_entry.kind  = kind;
   assign new_entry.id    = req_edge_id[EDGE_ID_BITS-1:0];
   assign new_entry.value = req_map_value[EDGE_ID_BITS-1:0];

   assign req_full = (count_ff == CMDQ_COUNT_BITS'(CMDQ_DEPTH)) || back_ctrl.init_busy;
   assign accept   = req_push && !req_full;
   assign wr       = accept && keep;
   assign rd       = back_ctrl.pop && (count_ff != '0);

   assign wr_ptr_in = wr ? wr_ptr_ff + CMDQ_PTR_BITS'(1) : wr_ptr_ff;
   assign rd_ptr_in = rd ? rd_ptr_ff + CMDQ_PTR_BITS'(1) : rd_ptr_ff;

   always_comb begin
      case ({wr, rd})
         2'b10:   count_in = count_ff + CMDQ_COUNT_BITS'(1);
         2'b01:   count_in = count_ff - CMDQ_COUNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign cmd_head.valid = (count_ff != '0);
   assign cmd_head.entry = entries_ff[rd_ptr_ff];

endmodule

>>> rtl/core/pec_rsp_fifo.sv
// ----------------------------------------------------------------------------
// pec_rsp_fifo: result queue
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module pec_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pec_pkg::rsp_item_type push_item,
   output logic                  full,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output pec_pkg::rsp_item_type head_item
);
   import pec_pkg::*;

   rsp_item_type               items_ff [RSPQ_DEPTH];
   logic [RSPQ_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSPQ_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSPQ_COUNT_BITS-1:0] count_ff, count_in;
   logic                       wr;
   logic                       rd;

   assign full      = (count_ff == RSPQ_COUNT_BITS'(RSPQ_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign wr        = push && !full;
   assign rd        = rsp_pop && !rsp_empty;

   assign wr_ptr_in = wr ? wr_ptr_ff + RSPQ_PTR_BITS'(1) : wr_ptr_ff;
   assign rd_ptr_in = rd ? rd_ptr_ff + RSPQ_PTR_BITS'(1) : rd_ptr_ff;

   always_comb begin
      case ({wr, rd})
         2'b10:   count_in = count_ff + RSPQ_COUNT_BITS'(1);
         2'b01:   count_in = count_ff - RSPQ_COUNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         items_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = items_ff[rd_ptr_ff];

endmodule

>>> rtl/core/pec_back.sv
// ----------------------------------------------------------------------------
// pec_back: execution side of the overlap check
// Sequencer over the edge map, seen bitmap and mark list memories.
// ----------------------------------------------------------------------------
module pec_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   use_map,
   input  pec_pkg::cmd_head_type  cmd_head,
   output pec_pkg::back_ctrl_type back_ctrl,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output pec_pkg::rsp_item_type  rsp_item
);
   import pec_pkg::*;

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_XLATE = 3'd2;
   localparam logic [2:0] ST_SEEN  = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [EDGE_ID_BITS-1:0]   init_addr_ff, init_addr_in;
   logic [EDGE_ID_BITS-1:0]   id_ff, id_in;
   logic                      is_mark_ff, is_mark_in;
   logic [LIST_ADDR_BITS-1:0] idx_ff, idx_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic                      overlap_ff, overlap_in;
   logic                      overflow_ff, overflow_in;
   logic [PATH_BITS-1:0]      path_ff, path_in;

   logic                      map_wr_en, map_rd_en;
   logic [EDGE_ID_BITS-1:0]   map_wr_addr, map_wr_data, map_rd_addr, map_rd_data;
   logic                      seen_wr_en, seen_rd_en;
   logic [EDGE_ID_BITS-1:0]   seen_wr_addr, seen_rd_addr;
   logic                      seen_wr_data, seen_rd_data;
   logic                      list_wr_en, list_rd_en;
   logic [LIST_ADDR_BITS-1:0] list_wr_addr, list_rd_addr;
   logic [EDGE_ID_BITS-1:0]   list_wr_data, list_rd_data;

   logic                      pop;
   logic                      start_clear;
   logic [PATH_BITS-1:0]      path_next;
   logic [COUNT_BITS-1:0]     idx_next;
   cmd_entry_type             head;

   assign head      = cmd_head.entry;
   assign path_next = (path_ff == PATH_MAX) ? path_ff : path_ff + PATH_BITS'(1);
   assign idx_next  = COUNT_BITS'(idx_ff) + COUNT_BITS'(1);

   assign rsp_item.path_number   = path_next;
   assign rsp_item.no_overlap    = !overlap_ff;
   assign rsp_item.list_overflow = overflow_ff;

   always_comb begin
      state_in     = state_ff;
      init_addr_in = init_addr_ff;
      id_in        = id_ff;
      is_mark_in   = is_mark_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      overlap_in   = overlap_ff;
      overflow_in  = overflow_ff;
      path_in      = path_ff;
      pop          = 1'b0;
      rsp_push     = 1'b0;
      start_clear  = 1'b0;
      map_wr_en    = 1'b0;
      map_wr_addr  = head.id;
      map_wr_data  = head.value;
      map_rd_en    = 1'b0;
      map_rd_addr  = head.id;
      seen_wr_en   = 1'b0;
      seen_wr_addr = id_ff;
      seen_wr_data = 1'b0;
      seen_rd_en   = 1'b0;
      seen_rd_addr = head.id;
      list_wr_en   = 1'b0;
      list_wr_addr = count_ff[LIST_ADDR_BITS-1:0];
      list_wr_data = id_ff;
      list_rd_en   = 1'b0;
      list_rd_addr = '0;

      case (state_ff)
         ST_INIT: begin
            seen_wr_en   = 1'b1;
            seen_wr_addr = init_addr_ff;
            init_addr_in = init_addr_ff + EDGE_ID_BITS'(1);
            if (init_addr_ff == {EDGE_ID_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_head.valid) begin
               case (head.kind)
                  KIND_LOAD: begin
                     pop       = 1'b1;
                     map_wr_en = 1'b1;
                  end
                  KIND_MARK, KIND_CHECK: begin
                     pop        = 1'b1;
                     is_mark_in = (head.kind == KIND_MARK);
                     if (use_map) begin
                        map_rd_en = 1'b1;
                        state_in  = ST_XLATE;
                     end else begin
                        seen_rd_en = 1'b1;
                        id_in      = head.id;
                        state_in   = ST_SEEN;
                     end
                  end
                  KIND_END: begin
                     if (!rsp_full) begin
                        pop         = 1'b1;
                        rsp_push    = 1'b1;
                        path_in     = path_next;
                        start_clear = 1'b1;
                     end
                  end
                  KIND_RESTART: begin
                     pop         = 1'b1;
                     path_in     = '0;
                     start_clear = 1'b1;
                  end
                  default: pop = 1'b1;
               endcase
               if (start_clear) begin
                  if (count_ff == '0) begin
                     overlap_in  = 1'b0;
                     overflow_in = 1'b0;
                  end else begin
                     list_rd_en = 1'b1;
                     idx_in     = '0;
                     state_in   = ST_CLEAR;
                  end
               end
            end
         end
         ST_XLATE: begin
            seen_rd_en   = 1'b1;
            seen_rd_addr = map_rd_data;
            id_in        = map_rd_data;
            state_in     = ST_SEEN;
         end
         ST_SEEN: begin
            state_in = ST_IDLE;
            if (is_mark_ff) begin
               if (!seen_rd_data) begin
                  if (count_ff >= COUNT_BITS'(MAX_PATH_EDGES)) begin
                     overflow_in = 1'b1;
                  end else begin
                     seen_wr_en   = 1'b1;
                     seen_wr_data = 1'b1;
                     list_wr_en   = 1'b1;
                     count_in     = count_ff + COUNT_BITS'(1);
                  end
               end
            end else if (seen_rd_data) begin
               overlap_in = 1'b1;
            end
         end
         ST_CLEAR: begin
            // list data for idx_ff is valid now
            seen_wr_en   = 1'b1;
            seen_wr_addr = list_rd_data;
            if (idx_next < count_ff) begin
               list_rd_en   = 1'b1;
               list_rd_addr = idx_next[LIST_ADDR_BITS-1:0];
               idx_in       = idx_next[LIST_ADDR_BITS-1:0];
            end else begin
               count_in    = '0;
               overlap_in  = 1'b0;
               overflow_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign back_ctrl.pop       = pop;
   assign back_ctrl.init_busy = (state_ff == ST_INIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_addr_ff <= '0;
         count_ff     <= '0;
         overlap_ff   <= 1'b0;
         overflow_ff  <= 1'b0;
         path_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         init_addr_ff <= init_addr_in;
         count_ff     <= count_in;
         overlap_ff   <= overlap_in;
         overflow_ff  <= overflow_in;
         path_ff      <= path_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      is_mark_ff <= is_mark_in;
      idx_ff     <= idx_in;
   end

   pec_ram #(.WIDTH(EDGE_ID_BITS), .DEPTH(ID_SPACE)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   pec_ram #(.WIDTH(1), .DEPTH(ID_SPACE)) u_seen_ram (
      .clock   (clock),
      .wr_en   (seen_wr_en),
      .wr_addr (seen_wr_addr),
      .wr_data (seen_wr_data),
      .rd_en   (seen_rd_en),
      .rd_addr (seen_rd_addr),
      .rd_data (seen_rd_data)
   );

   pec_ram #(.WIDTH(EDGE_ID_BITS), .DEPTH(MAX_PATH_EDGES)) u_list_ram (
      .clock   (clock),
      .wr_en   (list_wr_en),
      .wr_addr (list_wr_addr),
      .wr_data (list_wr_data),
      .rd_en   (list_rd_en),
      .rd_addr (list_rd_addr),
      .rd_data (list_rd_data)
   );

   // mark count never passes the list bound
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_PATH_EDGES))
      else $error("mark count above list bound");

   // the clearing walk stays inside the filled part of the list
   a_clear_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (COUNT_BITS'(idx_ff) < count_ff))
      else $error("clear walk beyond filled entries");

   // a result is only produced when the result queue has room
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");

   // commands are only taken from a non-empty queue, outside init
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cmd_head.valid && (state_ff == ST_IDLE)))
      else $error("command popped without a valid head");

   // after a finished walk the mark list is empty
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_CLEAR) && (state_in == ST_IDLE)) |=> (count_ff == '0))
      else $error("marks left after clear walk");

endmodule

>>> tb/sv/path_edge_overlap_check_tb.sv
// ----------------------------------------------------------------------------
// path_edge_overlap_check_tb: self-checking bench for the path overlap checker
// Streams map loads, first/second-part edges, end-of-path and restart items
// through the queue-style input port. A local model of the marks, the mark
// list and the edge map predicts every path result. A monitor compares each
// popped result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module path_edge_overlap_check_tb;
   import pec_pkg::*;

   // codes the block accepts and drops
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   // worst back-end work left after the last result: a full command queue
   // of restarts, each walking a full mark list
   localparam int SETTLE_CYCLES  = CMDQ_DEPTH * (MAX_PATH_EDGES + 8);
   // covers the bitmap clear after reset, the idling phases and the drains,
   // several times over
   localparam int TIMEOUT_CYCLES = 1_500_000;
   localparam int HOLD_START     = 20;    // cycles into the mapped run
   localparam int HOLD_LEN       = 600;   // receiver held off this long
   localparam int RUN_ITEMS      = 100;   // per random phase
   localparam int MAX_PRINTS     = 200;

   typedef enum logic [1:0] {
      PH_DIRECTED,
      PH_MAPPED_RUN,
      PH_PLAIN_RUN,
      PH_FAST_RUN
   } run_phase_type;

   typedef struct packed {
      logic [2:0]              command;
      logic [EDGE_ID_BITS-1:0] edge_id;
      logic [EDGE_ID_BITS-1:0] map_value;
   } path_cmd_type;

   // ---------------------------------------------------------------- DUT I/O
   // every input known from time zero
   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_push          = 1'b0;
   logic [2:0]  req_command       = CMD_LOAD_MAP;
   logic [15:0] req_edge_id       = '0;
   logic [15:0] req_map_value     = '0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop           = 1'b0;
   logic [15:0] rsp_path_number;
   logic        rsp_no_overlap;
   logic        rsp_list_overflow;
   logic        csr_wr_en         = 1'b0;
   logic        csr_wr_data       = 1'b0;

   path_edge_overlap_check u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_command       (req_command),
      .req_edge_id       (req_edge_id),
      .req_map_value     (req_map_value),
      .req_full          (req_full),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_path_number   (rsp_path_number),
      .rsp_no_overlap    (rsp_no_overlap),
      .rsp_list_overflow (rsp_list_overflow),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------ bench state
   path_cmd_type path_cmd_q[$];        // items waiting for the driver
   rsp_item_type path_results_q[$];    // predicted results, oldest first
   path_cmd_type offered;              // item currently on the req_ ports

   int unsigned   send_idle_pct = 23;
   int unsigned   recv_idle_pct = 70;
   run_phase_type phase_id      = PH_DIRECTED;
   logic          hold_on       = 1'b0;

   int cycle_cnt     = 0;
   int fail_cnt      = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int overlap_paths = 0;
   int spill_paths   = 0;
   int map_loads     = 0;

   // local model of the block
   bit                      mark_bits [ID_SPACE];
   logic [EDGE_ID_BITS-1:0] map_table [ID_SPACE];
   logic [EDGE_ID_BITS-1:0] mark_list [MAX_PATH_EDGES];
   int                      mark_total = 0;
   bit                      hit_seen   = 1'b0;
   bit                      spill_seen = 1'b0;
   logic [PATH_BITS-1:0]    path_total = '0;
   bit                      map_mode   = 1'b0;

   // generator bookkeeping: which map addresses have been loaded, so that a
   // mapped edge never goes through an entry that holds nothing yet
   bit                      gen_map_written [ID_SPACE];
   logic [EDGE_ID_BITS-1:0] gen_map_addrs[$];
   int                      gen_count = 0;

   // ------------------------------------------------------------- predictor
   function automatic void drop_marks();
      for (int i = 0; i < mark_total; i++) mark_bits[mark_list[i]] = 1'b0;
      mark_total = 0;
      hit_seen   = 1'b0;
      spill_seen = 1'b0;
   endfunction

   function automatic void apply_path_cmd(input path_cmd_type it);
      logic [EDGE_ID_BITS-1:0] id;
      rsp_item_type            res;
      id = it.edge_id;
      if (map_mode && (it.command == CMD_FIRST || it.command == CMD_SECOND))
         id = map_table[it.edge_id];
      case (it.command)
         CMD_LOAD_MAP: begin
            map_table[it.edge_id] = it.map_value;
            map_loads++;
         end
         CMD_FIRST: begin
            // a repeat is a no-op; a new id with the list full is dropped
            if (!mark_bits[id]) begin
               if (mark_total >= MAX_PATH_EDGES) begin
                  spill_seen = 1'b1;
               end else begin
                  mark_bits[id]         = 1'b1;
                  mark_list[mark_total] = id;
                  mark_total++;
               end
            end
         end
         CMD_SECOND: begin
            if (mark_bits[id]) hit_seen = 1'b1;
         end
         CMD_END_PATH: begin
            if (path_total != PATH_MAX) path_total++;
            res.path_number   = path_total;
            res.no_overlap    = !hit_seen;
            res.list_overflow = spill_seen;
            path_results_q.push_back(res);
            drop_marks();
         end
         CMD_RESTART: begin
            drop_marks();
            path_total = '0;
         end
         default: ;   // spare codes: accepted, nothing happens
      endcase
   endfunction

   // ---------------------------------------------------------------- report
   task automatic report_mismatch(input string what);
      fail_cnt++;
      if (fail_cnt <= MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
   endtask

   // ---------------------------------------------------------------- driver
   // An item moves at an edge with push high and full low. Prediction runs
   // on acceptance, so the expected queue stays in input order.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            apply_path_cmd(offered);
            items_sent++;
         end
         // hold the item while the block is full, else decide on the next
         if (!req_push || !req_full) begin
            if (path_cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered        = path_cmd_q.pop_front();
               req_push      <= 1'b1;
               req_command   <= offered.command;
               req_edge_id   <= offered.edge_id;
               req_map_value <= offered.map_value;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (path_results_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result, path %0d", rsp_path_number));
            end else begin
               want = path_results_q.pop_front();
               if (!want.no_overlap) overlap_paths++;
               if (want.list_overflow) spill_paths++;
               if (rsp_path_number !== want.path_number)
                  report_mismatch($sformatf("path_number %0d, want %0d",
                                            rsp_path_number, want.path_number));
               if (rsp_no_overlap !== want.no_overlap)
                  report_mismatch($sformatf("path %0d no_overlap %b, want %b",
                                            want.path_number, rsp_no_overlap,
                                            want.no_overlap));
               if (rsp_list_overflow !== want.list_overflow)
                  report_mismatch($sformatf("path %0d list_overflow %b, want %b",
                                            want.path_number, rsp_list_overflow,
                                            want.list_overflow));
            end
         end
         rsp_pop <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------ receiver hold-off
   // Once, during the mapped run, results stay unpopped long enough for the
   // result queue and then the command queue to fill and raise req_full.
   always @(posedge clock) begin
      int hold_cnt;
      bit hold_done;
      if (reset) begin
         hold_cnt  = 0;
         hold_done = 1'b0;
         hold_on  <= 1'b0;
      end else if (!hold_done && phase_id == PH_MAPPED_RUN) begin
         hold_cnt++;
         if (hold_cnt == HOLD_START) hold_on <= 1'b1;
         if (hold_cnt == HOLD_START + HOLD_LEN) begin
            hold_on  <= 1'b0;
            hold_done = 1'b1;
         end
      end
   end

   // --------------------------------------------------------------- timeout
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_cnt, path_results_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------- stimulus
   function automatic logic [15:0] rand16();
      return 16'($urandom());
   endfunction

   function automatic void queue_item(input logic [2:0] cmd, input logic [15:0] id,
                                      input logic [15:0] val);
      path_cmd_type it;
      it.command   = cmd;
      it.edge_id   = id;
      it.map_value = val;
      path_cmd_q.push_back(it);
      if (cmd == CMD_LOAD_MAP && !gen_map_written[id]) begin
         gen_map_written[id] = 1'b1;
         gen_map_addrs.push_back(id);
      end
      // spare codes are only ignored, they do not count as work
      if (cmd <= CMD_RESTART) gen_count++;
   endfunction

   // small values dominate so that several addresses share one undirected id
   function automatic logic [15:0] pick_map_value();
      if ($urandom_range(9) < 7) return 16'($urandom_range(63));
      return rand16();
   endfunction

   function automatic logic [15:0] pick_edge(input bit mapped);
      if (mapped) return gen_map_addrs[$urandom_range(gen_map_addrs.size() - 1)];
      if ($urandom_range(3) == 0) return rand16();
      return 16'($urandom_range(63));
   endfunction

   // One path: optional noise in front, first-part and second-part edges
   // (sometimes interleaved), then mostly an end of path. A few paths end in
   // a restart or run on into the next path.
   task automatic queue_random_path(input bit mapped);
      int                      r;
      int                      n_first;
      int                      n_second;
      bit                      mixed;
      logic [EDGE_ID_BITS-1:0] firsts[$];
      logic [EDGE_ID_BITS-1:0] id;
      r = $urandom_range(99);
      if (r < 10) begin
         repeat ($urandom_range(3, 1)) queue_item(CMD_LOAD_MAP, rand16(), pick_map_value());
      end else if (r < 14) begin
         queue_item(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), rand16(), rand16());
      end
      n_first  = $urandom_range(12);
      n_second = $urandom_range(12);
      mixed    = ($urandom_range(3) == 0);
      while (n_first + n_second > 0) begin
         if (n_first > 0 && (!mixed || n_second == 0 || $urandom_range(1) == 0)) begin
            if (firsts.size() != 0 && $urandom_range(4) == 0)
               id = firsts[$urandom_range(firsts.size() - 1)];   // repeated mark
            else
               id = pick_edge(mapped);
            firsts.push_back(id);
            queue_item(CMD_FIRST, id, rand16());
            n_first--;
         end else begin
            if (firsts.size() != 0 && $urandom_range(9) < 4)
               id = firsts[$urandom_range(firsts.size() - 1)];   // likely overlap
            else
               id = pick_edge(mapped);
            queue_item(CMD_SECOND, id, rand16());
            n_second--;
         end
      end
      r = $urandom_range(99);
      if (r < 90) queue_item(CMD_END_PATH, rand16(), rand16());
      else if (r < 96) queue_item(CMD_RESTART, rand16(), rand16());
   endtask

   task automatic queue_random_paths(input bit mapped, input int n);
      int start;
      start = gen_count;
      while (gen_count - start < n) queue_random_path(mapped);
   endtask

   // sender pause: nothing left to send, nothing on the port, nothing owed
   task automatic wait_results();
      @(negedge clock);
      while (path_cmd_q.size() != 0 || req_push || path_results_q.size() != 0)
         @(negedge clock);
   endtask

   // results done, then room for trailing items that produce none
   task automatic wait_idle();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_map_mode(input bit on);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      map_mode     = on;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // csr is taken while the bitmap clear still holds req_full high
      set_map_mode(1'b0);

      // ---- directed, ids used as they are
      queue_item(CMD_FIRST,    16'h0000, 16'hFFFF);
      queue_item(CMD_FIRST,    16'hFFFF, 16'h0000);
      queue_item(CMD_SECOND,   16'hFFFF, 16'hFFFF);   // overlap at top id
      queue_item(CMD_END_PATH, 16'h0000, 16'h0000);
      queue_item(CMD_FIRST,    16'h1234, 16'h0000);
      queue_item(CMD_FIRST,    16'h1234, 16'h0000);   // already marked
      queue_item(CMD_SECOND,   16'h4321, 16'h0000);
      queue_item(CMD_END_PATH, 16'hFFFF, 16'hFFFF);
      queue_item(CMD_END_PATH, 16'h5A5A, 16'hA5A5);   // empty path
      queue_item(CMD_SPARE_FIRST,        rand16(), rand16());
      queue_item(CMD_SPARE_FIRST + 3'd1, rand16(), rand16());
      queue_item(CMD_SPARE_LAST,         rand16(), rand16());
      queue_item(CMD_LOAD_MAP, 16'h0000, 16'hFFFF);
      queue_item(CMD_LOAD_MAP, 16'hFFFF, 16'h0000);
      queue_item(CMD_LOAD_MAP, 16'h5555, 16'h5555);
      queue_item(CMD_LOAD_MAP, 16'hAAAA, 16'h5555);   // reverse direction
      queue_item(CMD_LOAD_MAP, 16'h1111, 16'h0AAA);
      queue_item(CMD_RESTART,  16'h0000, 16'h0000);
      queue_item(CMD_END_PATH, 16'h0000, 16'h0000);   // path number back to 1
      queue_item(CMD_FIRST,    16'h0AAA, 16'h0000);   // path left open
      wait_idle();

      // ---- mode change inside the open path: the raw mark must still clear
      set_map_mode(1'b1);
      queue_item(CMD_FIRST,    16'h5555, 16'h0000);
      queue_item(CMD_SECOND,   16'hAAAA, 16'h0000);   // both directions -> 5555
      queue_item(CMD_SECOND,   16'h1111, 16'h0000);   // hits the unmapped mark
      queue_item(CMD_END_PATH, 16'h0000, 16'h0000);
      queue_item(CMD_FIRST,    16'h0000, 16'h0000);
      queue_item(CMD_SECOND,   16'hFFFF, 16'h0000);
      queue_item(CMD_END_PATH, 16'h0000, 16'h0000);
      wait_idle();

      // ---- mark list overflow, then a path to show the marks were cleared
      set_map_mode(1'b0);
      for (int i = 0; i < MAX_PATH_EDGES + 2; i++)
         queue_item(CMD_FIRST, 16'(16'h0100 + i), rand16());
      queue_item(CMD_SECOND,   16'(16'h0100 + MAX_PATH_EDGES + 1), 16'h0000);
      queue_item(CMD_END_PATH, 16'h0000, 16'h0000);
      queue_item(CMD_SECOND,   16'h0100, 16'h0000);
      queue_item(CMD_FIRST,    16'h0500, 16'h0000);
      queue_item(CMD_SECOND,   16'h0500, 16'h0000);
      queue_item(CMD_END_PATH, 16'h0000, 16'h0000);
      wait_idle();

      // ---- random, mapped: sender idles little, receiver a lot, long hold
      set_map_mode(1'b1);
      phase_id <= PH_MAPPED_RUN;
      queue_random_paths(1'b1, RUN_ITEMS);
      wait_idle();

      // ---- random, unmapped: roles swapped, sender drains halfway through
      set_map_mode(1'b0);
      phase_id      <= PH_PLAIN_RUN;
      send_idle_pct <= 70;
      recv_idle_pct <= 23;
      queue_random_paths(1'b0, RUN_ITEMS / 2);
      wait_results();
      queue_random_paths(1'b0, RUN_ITEMS / 2);
      wait_idle();

      // ---- random, mapped, no idling, then a restart and a fresh path count
      set_map_mode(1'b1);
      phase_id      <= PH_FAST_RUN;
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      queue_random_paths(1'b1, RUN_ITEMS);
      queue_item(CMD_RESTART,  rand16(), rand16());
      queue_item(CMD_END_PATH, rand16(), rand16());
      wait_idle();

      @(negedge clock);
      if (path_results_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", path_results_q.size()));
      $display("covered %0d items, %0d map loads, %0d path results checked",
               items_sent, map_loads, results_seen);
      $display("%0d paths with overlap, %0d with list overflow, %0d mismatches",
               overlap_paths, spill_paths, fail_cnt);
      if (fail_cnt == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> path_edge_overlap_check.f
rtl/core/pec_pkg.sv
rtl/core/pec_ram.sv
rtl/core/pec_front.sv
rtl/core/pec_rsp_fifo.sv
rtl/core/pec_back.sv
rtl/core/path_edge_overlap_check.sv
tb/sv/path_edge_overlap_check_tb.sv
